/* hdl/sha1h_pkg.sv */
`default_nettype none
package sha1h_pkg;
  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } item_t;
endpackage
`default_nettype wire

/* hdl/sha1h_queue.sv */
`default_nettype none
module sha1h_queue
  import sha1h_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  wire   out_ready,
  output item_t out_item
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + (AW+1)'(1))
    else $error("queue count lost a push");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - (AW+1)'(1))
    else $error("queue count lost a pop");
endmodule
`default_nettype wire

/* hdl/sha1h_core.sv */
`default_nettype none
module sha1h_core
  import sha1h_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_index,
  output logic        out_last
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RND   = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [31:0] h [5];
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [6:0] rnd;
  logic [5:0] fill;
  logic [60:0] msg_len;
  logic finishing;
  logic pad_started;
  logic len_here;
  logic [2:0] emit_idx;

  logic [7:0] pad_byte;
  logic [63:0] bit_len;
  logic [31:0] f, k, w_new, t, w_cur;

  assign bit_len = {msg_len, 3'b000};
  assign in_ready = (state == S_IDLE);

  always_comb begin
    if (!pad_started) begin
      pad_byte = PAD_BYTE;
    end else if (fill < LEN_START || !len_here) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = bit_len[8*(7 - (fill[2:0])) +: 8];
    end
  end

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_new[30:0], w_new[31]};
    w_cur = w[0];
    t = {a[26:0], a[31:27]} + f + e + k + w_cur;
  end

  assign out_valid = (state == S_EMIT);
  assign out_word = h[emit_idx];
  assign out_index = emit_idx;
  assign out_last = (emit_idx == 3'd4);

  // block bytes shift in big-endian through the schedule window
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
      rnd <= '0;
      fill <= '0;
      msg_len <= '0;
      finishing <= 1'b0;
      pad_started <= 1'b0;
      len_here <= 1'b0;
      emit_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.action == ACT_APPEND) begin
              w[fill[5:2]] <= {w[fill[5:2]][23:0], in_item.data};
              fill <= fill + 6'd1;
              msg_len <= msg_len + 61'd1;
              if (fill == 6'd63) begin
                state <= S_RND;
                rnd <= '0;
                a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
              end
            end else begin
              finishing <= 1'b1;
              pad_started <= 1'b0;
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          w[fill[5:2]] <= {w[fill[5:2]][23:0], pad_byte};
          pad_started <= 1'b1;
          if (!pad_started) begin
            len_here <= (fill < LEN_START);
          end
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_RND;
            rnd <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_new;
          e <= d;
          d <= c;
          c <= {b[1:0], b[31:2]};
          b <= a;
          a <= t;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (!finishing) begin
            state <= S_IDLE;
          end else if (len_here) begin
            state <= S_EMIT;
            emit_idx <= '0;
          end else begin
            len_here <= 1'b1;
            state <= S_PAD;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd4) begin
              state <= S_IDLE;
              h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
              fill <= '0;
              msg_len <= '0;
              finishing <= 1'b0;
              pad_started <= 1'b0;
              len_here <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_RND && rnd == 7'd79) |=> state == S_ADD)
    else $error("round count ran past 80");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_ready && emit_idx == 3'd4) |=> state == S_IDLE && fill == '0)
    else $error("digest end did not reset");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> emit_idx <= 3'd4)
    else $error("digest index out of range");
endmodule
`default_nettype wire

/* hdl/sha1_byte_stream_hasher.sv */
`default_nettype none
// SHA-1 over a byte stream. Each input transfer appends one byte (tuser = 0)
// or finishes the message (tuser = 1), which emits five digest words, word 0
// first, tlast on the fifth. A small input queue decouples the stream from the
// compression engine. An append writes the byte into the block buffer; every
// 64th byte starts a compression (80 rounds of the single round unit plus the
// final add), and the engine takes no bytes until it is done. A finish writes the
// padding one byte per cycle and runs one or two compressions before the
// digest words leave, one per accepted output transfer.
module sha1_byte_stream_hasher
  import sha1h_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire         s_tuser,   // [0] action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_tlast    // last_word
);
  item_t in_item;
  item_t q_item;
  logic q_valid;
  logic q_ready;
  logic [31:0] word;
  logic [2:0] idx;

  assign in_item.action = s_tuser;
  assign in_item.data = s_tdata;

  sha1h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  sha1h_core u_core (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_word(word), .out_index(idx), .out_last(m_tlast)
  );

  assign m_tdata = {5'b0, idx, word};
endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb
  import sha1h_pkg::*;
();

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam int unsigned WATCHDOG_CYCLES = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  item_t        pending_items[$];
  digest_word_t expected_words[$];
  logic [31:0]  chain[5];
  logic [7:0]   block[64];
  logic [5:0]   fill;
  logic [60:0]  msg_len;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  bit           hold_send;
  int unsigned  error_count = 0;
  int unsigned  idle_cycles;

  sha1_byte_stream_hasher u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic push_byte(input logic [7:0] v);
    block[fill] = v;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress_block();
  endtask

  task automatic clear_hash();
    chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
    fill = '0;
    msg_len = '0;
  endtask

  task automatic queue_item(input item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic hash_item(input item_t it);
    logic [63:0] bit_len;
    digest_word_t dw;
    if (it.action == ACT_APPEND) begin
      push_byte(it.data);
      msg_len = msg_len + 61'd1;
    end else begin
      bit_len = {msg_len, 3'b000};
      push_byte(PAD_BYTE);
      while (fill != LEN_START) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        dw.word = chain[i];
        dw.index = 3'(i);
        dw.last = (i == 4);
        expected_words.insert(expected_words.size(), dw);
      end
      clear_hash();
    end
  endtask

  task automatic add_message(input int unsigned n, input bit finish);
    for (int i = 0; i < n; i++) queue_item('{ACT_APPEND, 8'($urandom)});
    if (finish) queue_item('{ACT_FINISH, 8'($urandom)});
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      clear_hash();
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) hash_item('{s_tuser, s_tdata});
      if (pending_items.size() != 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        {s_tuser, s_tdata} <= pending_items.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_word_t got, exp;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[31:0], m_tdata[34:32], m_tlast};
        if (expected_words.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected digest word %h", got);
        end else begin
          exp = expected_words.pop_front();
          if (got !== exp || m_tdata[39:35] !== '0) begin
            error_count++;
            if (error_count <= 10)
              $display("digest mismatch: expected word %h index %0d last %0b, %s %h %0d %0b",
                       exp.word, exp.index, exp.last, "got",
                       got.word, got.index, got.last);
          end
        end
      end
      m_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    send_idle_pct = 0; recv_stall_pct = 0; hold_send = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    queue_item('{ACT_FINISH, 8'hFF});
    queue_item('{ACT_APPEND, 8'h00});
    queue_item('{ACT_APPEND, 8'hFF});
    queue_item('{ACT_APPEND, 8'h55});
    queue_item('{ACT_APPEND, 8'hAA});
    queue_item('{ACT_FINISH, 8'h00});
    add_message(55, 1);
    add_message(56, 1);
    add_message(64, 1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int m = 0; m < 3; m++) begin
        add_message($urandom_range(8), 1);
      end
      add_message($urandom_range(3), 0);
      wait_for_drain();
      hold_send = 1'b1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
      hold_send = 1'b0;
    end
    queue_item('{ACT_FINISH, 8'h00});
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hdl/sha1h_pkg.sv
hdl/sha1h_queue.sv
hdl/sha1h_core.sv
hdl/sha1_byte_stream_hasher.sv
bench/tb.sv
